### rtl/adx_pkg.sv
package adx_pkg;

    // Default sizes
    localparam int MAX_CHANNELS_DEF = 512;
    localparam int DATAGRAM_MAX_DEF = 2048;

    // ArtDmx header layout and checks
    localparam int          HDR_BYTES   = 18;
    localparam int          POS_OP_LO   = 8;
    localparam int          POS_OP_HI   = 9;
    localparam int          POS_VER_HI  = 10;
    localparam int          POS_VER_LO  = 11;
    localparam int          POS_SEQ     = 12;
    localparam int          POS_PORT_LO = 14;
    localparam int          POS_PORT_HI = 15;
    localparam int          POS_LEN_HI  = 16;
    localparam int          POS_LEN_LO  = 17;
    localparam logic [15:0] ARTDMX_OP   = 16'h5000;
    localparam logic [15:0] MIN_VERSION = 16'd14;
    localparam logic [7:0]  SEQ_WRAP    = 8'd255;

    localparam int CNT_W = 32;
    localparam int LEN_W = 16;

    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_ACCEPTED = 2'd1,
        VERDICT_INVALID  = 2'd2,
        VERDICT_IGNORED  = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        REG_DEST_PORT      = 2'd0,
        REG_SOURCE_FILTER  = 2'd1,
        REG_FILTER_ENABLE  = 2'd2
    } reg_index_t;

    // Control from the parser to the frame store
    typedef struct packed {
        logic advance;
        logic wr_en;
        logic rd_en;
        logic bank;
    } store_ctl_t;

    // Byte of the "Art-Net" ID with its trailing zero
    function automatic logic [7:0] art_id_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h72;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h2D;
            3'd4:    b = 8'h4E;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h74;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

### rtl/adx_in_if.sv
interface adx_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] source_ip;
    logic [8:0]  channel;

    modport source (output valid, cmd, data_byte, last_byte, source_ip, channel,
                    input ready);
    modport sink   (input valid, cmd, data_byte, last_byte, source_ip, channel,
                    output ready);
endinterface

### rtl/adx_out_if.sv
interface adx_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic        sequence_gap;
    logic [7:0]  read_data;
    logic        frame_valid;
    logic [31:0] received_count;
    logic [31:0] accepted_count;
    logic [31:0] invalid_count;
    logic [31:0] ignored_count;
    logic [31:0] gap_count;

    modport source (output valid, verdict, sequence_gap, read_data, frame_valid,
                    received_count, accepted_count, invalid_count, ignored_count,
                    gap_count,
                    input ready);
    modport sink   (input valid, verdict, sequence_gap, read_data, frame_valid,
                    received_count, accepted_count, invalid_count, ignored_count,
                    gap_count,
                    output ready);
endinterface

### rtl/adx_frame_store.sv
module adx_frame_store
    import adx_pkg::*;
#(
    parameter int CH_W = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_ctl_t       ctl,
    input  logic [CH_W-1:0]  wr_ch,
    input  logic [7:0]       wr_data,
    input  logic [CH_W-1:0]  rd_ch,
    output logic [7:0]       read_data
);

    localparam int DEPTH = 2 ** (CH_W + 1);

    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] rd_data_reg;
    logic       rd_en_reg;

    // Write into the idle bank, read from the active bank
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[{~ctl.bank, wr_ch}] <= wr_data;
        end
        if (ctl.advance)
        begin
            rd_data_reg <= mem[{ctl.bank, rd_ch}];
        end
    end

    // Remember whether the held transfer is an in-range read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_en_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            rd_en_reg <= ctl.rd_en;
        end
    end

    assign read_data = rd_en_reg ? rd_data_reg : 8'd0;

endmodule

### rtl/artdmx_packet_receiver.sv
// Channel   Dir   Handshake        Payload
// item      in    valid/ready      cmd, data_byte, last_byte, source_ip, channel
// result    out   valid/ready      verdict, sequence_gap, read_data, frame_valid, counts
// apb       in    psel/penable     dest port, source_filter_ip, source_filter_enable
//
// One item per clock unless the result stalls; each item yields one result the next cycle.
// Parsing, verdict and counter updates sit between the item and the result register;
// a channel read goes through the frame store's registered read port.
// item.ready is high while the result register is empty or being taken, so a
// stalled result holds the next item off. Reset clears all control state; no clearing pass.
module artdmx_packet_receiver
    import adx_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int DATAGRAM_MAX = DATAGRAM_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    adx_in_if.sink      item,
    adx_out_if.source   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CH_W  = $clog2(MAX_CHANNELS);
    localparam int IDX_W = $clog2(DATAGRAM_MAX + 1);
    localparam int NEED_W = LEN_W + 1;

    // Configuration registers
    logic [14:0] dest_port_reg;
    logic [31:0] source_filter_ip_reg;
    logic        source_filter_enable_reg;
    reg_index_t  cfg_index;
    logic        cfg_write;

    // Parser state
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             id_match_reg, id_match_next;
    logic [7:0]       vhi_reg, vhi_next;
    logic [7:0]       seq_reg, seq_next;
    logic [14:0]      port_reg, port_next;
    logic [LEN_W-1:0] len_reg, len_next;

    // Frame and sequence state
    logic        active_bank_reg, active_bank_next;
    logic [9:0]  active_length_reg, active_length_next;
    logic        has_frame_reg, has_frame_next;
    logic [7:0]  last_seq_reg, last_seq_next;
    logic [31:0] last_src_reg, last_src_next;

    // Counters
    logic [CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [CNT_W-1:0] acc_count_reg, acc_count_next;
    logic [CNT_W-1:0] inv_count_reg, inv_count_next;
    logic [CNT_W-1:0] ign_count_reg, ign_count_next;
    logic [CNT_W-1:0] gap_count_reg, gap_count_next;

    // Result register
    logic     res_valid_reg;
    verdict_t verdict_reg, verdict_next;
    logic     gap_reg, gap_next;

    logic             accept;
    logic             take;
    logic             close;
    logic             in_range;
    logic [IDX_W-1:0] payload_off;
    logic             wr_en;
    logic             rd_en;
    logic             len_ok;
    logic             size_ok;
    logic             pkt_ok;
    logic             dest_ok;
    logic [7:0]       seq_want;
    store_ctl_t       store_ctl;

    assign accept     = item.valid && item.ready;
    assign item.ready = !res_valid_reg || result.ready;
    assign take       = accept && !item.cmd;
    assign close      = take && item.last_byte;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_index)
            REG_DEST_PORT:     prdata = {17'd0, dest_port_reg};
            REG_SOURCE_FILTER: prdata = source_filter_ip_reg;
            REG_FILTER_ENABLE: prdata = {31'd0, source_filter_enable_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_port_reg            <= 15'd0;
            source_filter_ip_reg     <= 32'd0;
            source_filter_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEST_PORT:     dest_port_reg            <= pwdata[14:0];
                REG_SOURCE_FILTER: source_filter_ip_reg     <= pwdata;
                REG_FILTER_ENABLE: source_filter_enable_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    // Header capture and payload write for one byte
    assign in_range    = idx_reg < IDX_W'(DATAGRAM_MAX);
    assign payload_off = idx_reg - IDX_W'(HDR_BYTES);

    always_comb
    begin
        idx_next      = idx_reg;
        id_match_next = id_match_reg;
        vhi_next      = vhi_reg;
        seq_next      = seq_reg;
        port_next     = port_reg;
        len_next      = len_reg;
        wr_en         = 1'b0;
        if (take && in_range)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (idx_reg < IDX_W'(POS_OP_LO))
            begin
                if (item.data_byte != art_id_byte(idx_reg[2:0]))
                begin
                    id_match_next = 1'b0;
                end
            end
            else if (idx_reg == IDX_W'(POS_OP_LO))
            begin
                if (item.data_byte != ARTDMX_OP[7:0])
                begin
                    id_match_next = 1'b0;
                end
            end
            else if (idx_reg == IDX_W'(POS_OP_HI))
            begin
                if (item.data_byte != ARTDMX_OP[15:8])
                begin
                    id_match_next = 1'b0;
                end
            end
            else if (idx_reg == IDX_W'(POS_VER_HI))
            begin
                vhi_next = item.data_byte;
            end
            else if (idx_reg == IDX_W'(POS_VER_LO))
            begin
                if ({vhi_reg, item.data_byte} < MIN_VERSION)
                begin
                    id_match_next = 1'b0;
                end
            end
            else if (idx_reg == IDX_W'(POS_SEQ))
            begin
                seq_next = item.data_byte;
            end
            else if (idx_reg == IDX_W'(POS_PORT_LO))
            begin
                port_next[7:0] = item.data_byte;
            end
            else if (idx_reg == IDX_W'(POS_PORT_HI))
            begin
                port_next[14:8] = item.data_byte[6:0];
            end
            else if (idx_reg == IDX_W'(POS_LEN_HI))
            begin
                len_next[15:8] = item.data_byte;
            end
            else if (idx_reg == IDX_W'(POS_LEN_LO))
            begin
                len_next[7:0] = item.data_byte;
            end
            else if (idx_reg >= IDX_W'(HDR_BYTES))
            begin
                wr_en = payload_off < IDX_W'(MAX_CHANNELS);
            end
        end
    end

    // Verdict checks at the closing byte
    assign len_ok  = (len_next >= LEN_W'(2)) && (len_next <= LEN_W'(MAX_CHANNELS))
                     && !len_next[0];
    assign size_ok = (idx_next >= IDX_W'(HDR_BYTES))
                     && (NEED_W'(idx_next) >= NEED_W'(HDR_BYTES) + NEED_W'(len_next));
    assign pkt_ok  = size_ok && id_match_next && len_ok;
    assign dest_ok = (port_next == dest_port_reg)
                     && (!source_filter_enable_reg
                         || (item.source_ip == source_filter_ip_reg));
    assign seq_want = (last_seq_reg == SEQ_WRAP) ? 8'd1 : last_seq_reg + 8'd1;

    always_comb
    begin
        verdict_next       = VERDICT_NONE;
        gap_next           = 1'b0;
        active_bank_next   = active_bank_reg;
        active_length_next = active_length_reg;
        has_frame_next     = has_frame_reg;
        last_seq_next      = last_seq_reg;
        last_src_next      = last_src_reg;
        rx_count_next      = rx_count_reg;
        acc_count_next     = acc_count_reg;
        inv_count_next     = inv_count_reg;
        ign_count_next     = ign_count_reg;
        gap_count_next     = gap_count_reg;
        if (close)
        begin
            rx_count_next = sat_inc(rx_count_reg);
            if (!pkt_ok)
            begin
                verdict_next   = VERDICT_INVALID;
                inv_count_next = sat_inc(inv_count_reg);
            end
            else if (!dest_ok)
            begin
                verdict_next   = VERDICT_IGNORED;
                ign_count_next = sat_inc(ign_count_reg);
            end
            else
            begin
                verdict_next = VERDICT_ACCEPTED;
                // Track the sequence of the last sequenced source; zero means unsequenced
                if (seq_next != 8'd0)
                begin
                    if ((last_seq_reg != 8'd0) && (item.source_ip == last_src_reg)
                        && (seq_next != seq_want))
                    begin
                        gap_next       = 1'b1;
                        gap_count_next = sat_inc(gap_count_reg);
                    end
                    last_seq_next = seq_next;
                    last_src_next = item.source_ip;
                end
                active_bank_next   = ~active_bank_reg;
                active_length_next = len_next[9:0];
                has_frame_next     = 1'b1;
                acc_count_next     = sat_inc(acc_count_reg);
            end
        end
    end

    // Parser registers: restart after the closing byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            id_match_reg <= 1'b1;
            vhi_reg      <= 8'd0;
            seq_reg      <= 8'd0;
            port_reg     <= 15'd0;
            len_reg      <= '0;
        end
        else if (close)
        begin
            idx_reg      <= '0;
            id_match_reg <= 1'b1;
            vhi_reg      <= 8'd0;
            seq_reg      <= 8'd0;
            port_reg     <= 15'd0;
            len_reg      <= '0;
        end
        else
        begin
            idx_reg      <= idx_next;
            id_match_reg <= id_match_next;
            vhi_reg      <= vhi_next;
            seq_reg      <= seq_next;
            port_reg     <= port_next;
            len_reg      <= len_next;
        end
    end

    // Frame, sequence and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bank_reg   <= 1'b0;
            active_length_reg <= 10'd0;
            has_frame_reg     <= 1'b0;
            last_seq_reg      <= 8'd0;
            last_src_reg      <= 32'd0;
            rx_count_reg      <= '0;
            acc_count_reg     <= '0;
            inv_count_reg     <= '0;
            ign_count_reg     <= '0;
            gap_count_reg     <= '0;
        end
        else
        begin
            active_bank_reg   <= active_bank_next;
            active_length_reg <= active_length_next;
            has_frame_reg     <= has_frame_next;
            last_seq_reg      <= last_seq_next;
            last_src_reg      <= last_src_next;
            rx_count_reg      <= rx_count_next;
            acc_count_reg     <= acc_count_next;
            inv_count_reg     <= inv_count_next;
            ign_count_reg     <= ign_count_next;
            gap_count_reg     <= gap_count_next;
        end
    end

    // Result register: load on each item transfer, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            verdict_reg   <= VERDICT_NONE;
            gap_reg       <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
            verdict_reg   <= verdict_next;
            gap_reg       <= gap_next;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Channel read of the active frame
    assign rd_en = accept && item.cmd
                   && (10'(item.channel) < active_length_reg)
                   && (10'(item.channel) < 10'(MAX_CHANNELS));

    assign store_ctl.advance = accept;
    assign store_ctl.wr_en   = wr_en;
    assign store_ctl.rd_en   = rd_en;
    assign store_ctl.bank    = active_bank_reg;

    adx_frame_store #(
        .CH_W (CH_W)
    ) u_frame_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (store_ctl),
        .wr_ch     (payload_off[CH_W-1:0]),
        .wr_data   (item.data_byte),
        .rd_ch     (item.channel[CH_W-1:0]),
        .read_data (result.read_data)
    );

    // Counters and frame flag hold while the result waits
    assign result.valid          = res_valid_reg;
    assign result.verdict        = verdict_reg;
    assign result.sequence_gap   = gap_reg;
    assign result.frame_valid    = has_frame_reg;
    assign result.received_count = rx_count_reg;
    assign result.accepted_count = acc_count_reg;
    assign result.invalid_count  = inv_count_reg;
    assign result.ignored_count  = ign_count_reg;
    assign result.gap_count      = gap_count_reg;

endmodule

### rtl/adx_checker.sv
module adx_checker
    import adx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  verdict,
    input logic        sequence_gap,
    input logic        frame_valid,
    input logic [31:0] received_count,
    input logic [31:0] accepted_count
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(verdict) && $stable(received_count))
        else $error("result changed while stalled");

    // Received count never falls
    a_rx_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> received_count >= $past(received_count))
        else $error("received count decreased");

    // An accepted packet leaves a frame and a count behind
    a_accept_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (verdict == VERDICT_ACCEPTED) |->
            frame_valid && (accepted_count != 32'd0))
        else $error("accepted verdict without frame or count");

    // Flag a gap only on an accepted packet
    a_gap_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sequence_gap |-> verdict == VERDICT_ACCEPTED)
        else $error("sequence gap on non-accepted result");

    // Any verdict means a datagram was counted
    a_verdict_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (verdict != VERDICT_NONE) |-> received_count != 32'd0)
        else $error("verdict without received datagram");

endmodule

bind artdmx_packet_receiver adx_checker u_adx_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .verdict        (result.verdict),
    .sequence_gap   (result.sequence_gap),
    .frame_valid    (result.frame_valid),
    .received_count (result.received_count),
    .accepted_count (result.accepted_count)
);
